// ===== hdl/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

   // Default queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // Phase counter width, enough for the 24 phases of a write byte
   localparam int PH_W = 5;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_SACK  = 3'd4,
      CMD_RACK  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       ack_bit;
      logic [7:0] line_bits;
      logic       line_ack;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       last;
      logic [7:0] read_value;
   } rsp_type;

   // Classified command: byte to drive, or value to report
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } desc_type;

   function automatic logic [PH_W-1:0] last_phase(input cmd_type cmd);
      logic [PH_W-1:0] ph;
      case (cmd)
         CMD_START: ph = PH_W'(3);
         CMD_STOP:  ph = PH_W'(2);
         CMD_WRITE: ph = PH_W'(23);
         CMD_READ:  ph = PH_W'(16);
         CMD_SACK:  ph = PH_W'(2);
         CMD_RACK:  ph = PH_W'(2);
         default:   ph = '0;
      endcase
      return ph;
   endfunction

endpackage

// ===== hdl/i2cmbs_fifo.sv =====
module i2cmbs_fifo #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type wr_data,
   output logic     full,
   input  logic     pop,
   output data_type rd_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type             mem_ff [DEPTH];
   logic     [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic     [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic     [CNT_W-1:0] count_ff,  count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hdl/i2cmbs_front.sv =====
module i2cmbs_front (
   input  logic                 push,
   input  i2cmbs_pkg::req_type  req_data,
   output logic                 full,
   output logic                 cmd_push,
   output i2cmbs_pkg::desc_type cmd_desc,
   input  logic                 cmd_full
);

   logic known;

   assign full = cmd_full;

   // unused action codes are taken and dropped
   always_comb begin
      known         = 1'b1;
      cmd_desc.cmd  = i2cmbs_pkg::cmd_type'(req_data.action);
      cmd_desc.data = '0;
      case (req_data.action)
         i2cmbs_pkg::CMD_START, i2cmbs_pkg::CMD_STOP: cmd_desc.data = '0;
         i2cmbs_pkg::CMD_WRITE: cmd_desc.data = req_data.tx_byte;
         i2cmbs_pkg::CMD_READ:  cmd_desc.data = req_data.line_bits;
         i2cmbs_pkg::CMD_SACK:  cmd_desc.data = {7'd0, req_data.ack_bit};
         i2cmbs_pkg::CMD_RACK:  cmd_desc.data = {7'd0, req_data.line_ack};
         default:               known = 1'b0;
      endcase
   end

   assign cmd_push = push && known;

endmodule

// ===== hdl/i2cmbs_back.sv =====
module i2cmbs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  i2cmbs_pkg::desc_type head,
   input  logic                 head_valid,
   output logic                 cmd_pop,
   output logic                 out_push,
   output i2cmbs_pkg::rsp_type  out_data,
   input  logic                 out_full
);

   logic [i2cmbs_pkg::PH_W-1:0] ph_ff, ph_in;
   logic [1:0]                  sub_ff, sub_in;
   logic [2:0]                  bit_ff, bit_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        scl_en, scl_val, sda_en, sda_val, fin;

   assign out_push = head_valid && !out_full;
   assign fin      = (ph_ff == i2cmbs_pkg::last_phase(head.cmd));
   assign cmd_pop  = out_push && fin;

   // which pin this phase moves, and to what
   always_comb begin
      scl_en  = 1'b0;
      scl_val = 1'b0;
      sda_en  = 1'b0;
      sda_val = 1'b0;
      case (head.cmd)
         i2cmbs_pkg::CMD_START: begin
            case (ph_ff[1:0])
               2'd0:    begin sda_en = 1'b1; sda_val = 1'b1; end
               2'd1:    begin scl_en = 1'b1; scl_val = 1'b1; end
               2'd2:    begin sda_en = 1'b1; sda_val = 1'b0; end
               default: begin scl_en = 1'b1; scl_val = 1'b0; end
            endcase
         end
         i2cmbs_pkg::CMD_STOP: begin
            case (ph_ff[1:0])
               2'd0:    begin sda_en = 1'b1; sda_val = 1'b0; end
               2'd1:    begin scl_en = 1'b1; scl_val = 1'b1; end
               default: begin sda_en = 1'b1; sda_val = 1'b1; end
            endcase
         end
         i2cmbs_pkg::CMD_WRITE: begin
            case (sub_ff)
               2'd0:    begin sda_en = 1'b1; sda_val = head.data[~bit_ff]; end
               2'd1:    begin scl_en = 1'b1; scl_val = 1'b1; end
               default: begin scl_en = 1'b1; scl_val = 1'b0; end
            endcase
         end
         i2cmbs_pkg::CMD_READ: begin
            if (ph_ff == '0) begin
               sda_en  = 1'b1;
               sda_val = 1'b1;
            end else begin
               scl_en  = 1'b1;
               scl_val = ph_ff[0];
            end
         end
         i2cmbs_pkg::CMD_SACK, i2cmbs_pkg::CMD_RACK: begin
            case (ph_ff[1:0])
               2'd0: begin
                  sda_en  = 1'b1;
                  sda_val = (head.cmd == i2cmbs_pkg::CMD_SACK) ? head.data[0] : 1'b1;
               end
               2'd1:    begin scl_en = 1'b1; scl_val = 1'b1; end
               default: begin scl_en = 1'b1; scl_val = 1'b0; end
            endcase
         end
         default: begin
            scl_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_data.scl        = scl_en ? scl_val : scl_ff;
      out_data.sda        = sda_en ? sda_val : sda_ff;
      out_data.last       = fin;
      out_data.read_value = (fin && (head.cmd == i2cmbs_pkg::CMD_READ ||
                                     head.cmd == i2cmbs_pkg::CMD_RACK)) ? head.data : '0;
   end

   always_comb begin
      ph_in  = ph_ff;
      sub_in = sub_ff;
      bit_in = bit_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      if (out_push) begin
         scl_in = out_data.scl;
         sda_in = out_data.sda;
         if (fin) begin
            ph_in  = '0;
            sub_in = '0;
            bit_in = '0;
         end else begin
            ph_in  = ph_ff + i2cmbs_pkg::PH_W'(1);
            sub_in = (sub_ff == 2'd2) ? 2'd0 : sub_ff + 2'd1;
            bit_in = bit_ff + 3'((sub_ff == 2'd2) ? 1 : 0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= '0;
         sub_ff <= '0;
         bit_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
      end else begin
         ph_ff  <= ph_in;
         sub_ff <= sub_in;
         bit_ff <= bit_in;
         scl_ff <= scl_in;
         sda_ff <= sda_in;
      end
   end

endmodule

// ===== hdl/i2c_master_bit_sequencer_core.sv =====
// Path: a command is registered in the command queue, then each of its phases in the phase
//   queue, from which rsp_data shows the phase at its head.
// Throughput: one pin phase per cycle while the phase queue has room, set by the phase
//   sequencer in the back end; each command expands into its own sequence of pin phases.
// Reset: synchronous, active high; empties both queues, parks SCL and SDA high.
// Unused action codes are taken and yield no transfer.
module i2c_master_bit_sequencer_core #(
   parameter int CMD_DEPTH = i2cmbs_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = i2cmbs_pkg::RSP_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   // command side
   input  logic                push,
   output logic                full,
   input  i2cmbs_pkg::req_type req_data,
   // phase side
   output logic                empty,
   input  logic                pop,
   output i2cmbs_pkg::rsp_type rsp_data
);

   // front end -> command queue
   logic                 cmd_push, cmd_full;
   i2cmbs_pkg::desc_type cmd_desc;

   // command queue -> back end
   logic                 cmd_pop, cmd_empty;
   i2cmbs_pkg::desc_type cmd_head;

   // back end -> phase queue
   logic                 out_push, out_full;
   i2cmbs_pkg::rsp_type  out_data;

   // Front: decode the action, drop unused codes, pick the byte that matters
   i2cmbs_front u_front (
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_desc (cmd_desc),
      .cmd_full (cmd_full)
   );

   // Short command queue so the front keeps taking commands during a long byte
   i2cmbs_fifo #(
      .data_type (i2cmbs_pkg::desc_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_desc),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_head),
      .empty   (cmd_empty)
   );

   // Back: walks the head command one phase per cycle unless the phase queue is full;
   // it holds the pin levels, so a new command picks up SCL and SDA where the last one
   // left them. The head entry is retired with its final phase.
   i2cmbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (cmd_head),
      .head_valid (!cmd_empty),
      .cmd_pop    (cmd_pop),
      .out_push   (out_push),
      .out_data   (out_data),
      .out_full   (out_full)
   );

   // Phase queue: decouples the sequencer from a stalled consumer and, while not full,
   // lets a transfer out and a new phase in share a cycle.
   i2cmbs_fifo #(
      .data_type (i2cmbs_pkg::rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

// ===== hdl/i2cmbs_checker.sv =====
module i2cmbs_checker (
   input logic                clock,
   input logic                reset,
   input logic                full,
   input logic                empty,
   input logic                pop,
   input i2cmbs_pkg::rsp_type rsp_data
);

   // reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a sampled value only ever rides on the final phase
   a_value_on_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.last) |-> (rsp_data.read_value == 8'd0))
      else $error("read value outside final phase");

   // every command ends with SCL low, except stop, which ends with both lines high
   a_end_levels: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last) |-> (!rsp_data.scl || rsp_data.sda))
      else $error("bad pin levels at end of command");

   // a waiting phase is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting phase changed");

endmodule

bind i2c_master_bit_sequencer_core i2cmbs_checker u_i2cmbs_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

// ===== verif/i2cmbs_phase_checker.sv =====
`timescale 1ns / 1ps

module i2cmbs_phase_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                full,
   input  i2cmbs_pkg::req_type req_data,
   input  logic                empty,
   input  logic                pop,
   input  i2cmbs_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending
);

   i2cmbs_pkg::rsp_type expected_phases[$];
   logic                scl_lvl;
   logic                sda_lvl;
   int                  err_n;

   initial begin
      err_n      = 0;
      fail_count = 0;
      pending    = 0;
      scl_lvl    = 1'b1;
      sda_lvl    = 1'b1;
   end

   task automatic put_phase(input logic scl, input logic sda, input logic fin,
                            input logic [7:0] val);
      i2cmbs_pkg::rsp_type p;
      scl_lvl      = scl;
      sda_lvl      = sda;
      p.scl        = scl;
      p.sda        = sda;
      p.last       = fin;
      p.read_value = fin ? val : 8'h00;
      expected_phases.push_back(p);
   endtask

   // Expand one bus command into its pin phases
   task automatic expand_command(input i2cmbs_pkg::req_type r);
      logic [7:0] acc;
      acc = 8'h00;
      case (r.action)
         i2cmbs_pkg::CMD_START: begin
            put_phase(scl_lvl, 1'b1, 1'b0, 8'h00);
            put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
            put_phase(scl_lvl, 1'b0, 1'b0, 8'h00);
            put_phase(1'b0, sda_lvl, 1'b1, 8'h00);
         end
         i2cmbs_pkg::CMD_STOP: begin
            put_phase(scl_lvl, 1'b0, 1'b0, 8'h00);
            put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
            put_phase(scl_lvl, 1'b1, 1'b1, 8'h00);
         end
         i2cmbs_pkg::CMD_WRITE: begin
            for (int i = 0; i < 8; i++) begin
               put_phase(scl_lvl, r.tx_byte[7-i], 1'b0, 8'h00);
               put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
               put_phase(1'b0, sda_lvl, i == 7, 8'h00);
            end
         end
         i2cmbs_pkg::CMD_READ: begin
            put_phase(scl_lvl, 1'b1, 1'b0, 8'h00);
            for (int i = 0; i < 8; i++) begin
               put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
               acc[7-i] = r.line_bits[7-i];
               put_phase(1'b0, sda_lvl, i == 7, acc);
            end
         end
         i2cmbs_pkg::CMD_SACK: begin
            put_phase(scl_lvl, r.ack_bit, 1'b0, 8'h00);
            put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
            put_phase(1'b0, sda_lvl, 1'b1, 8'h00);
         end
         i2cmbs_pkg::CMD_RACK: begin
            put_phase(scl_lvl, 1'b1, 1'b0, 8'h00);
            put_phase(1'b1, sda_lvl, 1'b0, 8'h00);
            put_phase(1'b0, sda_lvl, 1'b1, {7'd0, r.line_ack});
         end
         default: ; // spare codes: no phases, pins untouched
      endcase
   endtask

   task automatic compare_field(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         err_n++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      i2cmbs_pkg::rsp_type want;
      if (reset) begin
         expected_phases.delete();
         scl_lvl = 1'b1;
         sda_lvl = 1'b1;
      end else begin
         if (pop && !empty) begin
            if (expected_phases.size() == 0) begin
               err_n++;
               $display("%0t: unexpected phase, expected none, got %0h", $time, rsp_data);
            end else begin
               want = expected_phases.pop_front();
               compare_field("scl", 8'(want.scl), 8'(rsp_data.scl));
               compare_field("sda", 8'(want.sda), 8'(rsp_data.sda));
               compare_field("last", 8'(want.last), 8'(rsp_data.last));
               compare_field("read_value", want.read_value, rsp_data.read_value);
            end
         end
         if (push && !full)
            expand_command(req_data);
      end
      pending    <= expected_phases.size();
      fail_count <= err_n;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // Spare action codes, expected to be swallowed without phases
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 300;
   localparam int CYCLE_LIMIT  = 400000;
   // Tail after the last phase
   localparam int TAIL_CYCLES  = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push  = 1'b0;
   logic                pop   = 1'b0;
   logic                full;
   logic                empty;
   i2cmbs_pkg::req_type req_data = '0;
   i2cmbs_pkg::rsp_type rsp_data;

   // When set, neither side idles
   logic    steady = 1'b0;
   int      n_sent = 0;
   int      cycles = 0;
   int      fail_count;
   int      pending;

   always #5 clock = ~clock;

   i2c_master_bit_sequencer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   i2cmbs_phase_checker phase_chk (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Phase consumer: stalls about a fifth of the time unless steady
   always @(posedge clock) begin
      if (reset)
         pop <= 1'b0;
      else if (steady)
         pop <= 1'b1;
      else
         pop <= ($urandom_range(99) >= 21);
   end

   function automatic i2cmbs_pkg::req_type make_item(input logic [2:0] act,
                                                     input logic [7:0] tx,
                                                     input logic ack,
                                                     input logic [7:0] lb,
                                                     input logic la);
      i2cmbs_pkg::req_type r;
      r.action    = act;
      r.tx_byte   = tx;
      r.ack_bit   = ack;
      r.line_bits = lb;
      r.line_ack  = la;
      return r;
   endfunction

   // Command with all unused fields randomised too
   function automatic i2cmbs_pkg::req_type rand_item(input logic [2:0] act);
      return make_item(act, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
   endfunction

   // One command transfer; push is left high so back-to-back items stay glued
   task automatic send(input i2cmbs_pkg::req_type r);
      while (!steady && $urandom_range(99) < 21) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      n_sent++;
      // long idle-free stretch in the middle of the random part
      steady <= (n_sent >= 150 && n_sent < 230);
   endtask

   // Hold off until every expected phase has been popped
   task automatic drain;
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Well-formed transaction: start, address, ack, data with acks, and mostly a stop
   task automatic send_transaction;
      i2cmbs_pkg::req_type addr;
      int                  n_data;
      addr   = rand_item(i2cmbs_pkg::CMD_WRITE);
      n_data = $urandom_range(1, 4);
      send(rand_item(i2cmbs_pkg::CMD_START));
      send(addr);
      send(rand_item(i2cmbs_pkg::CMD_RACK));
      for (int k = 0; k < n_data; k++) begin
         if (addr.tx_byte[0]) begin
            send(rand_item(i2cmbs_pkg::CMD_READ));
            send(rand_item(i2cmbs_pkg::CMD_SACK));
         end else begin
            send(rand_item(i2cmbs_pkg::CMD_WRITE));
            send(rand_item(i2cmbs_pkg::CMD_RACK));
         end
      end
      // now and then a transaction is cut short without its stop
      if ($urandom_range(99) >= 10)
         send(rand_item(i2cmbs_pkg::CMD_STOP));
   endtask

   initial begin
      int pick;
      int n_noise;
      int rand_base;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every command, field extremes, spare codes
      send(make_item(i2cmbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_RACK, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_RACK, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_READ, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_READ, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_READ, 8'h00, 1'b0, 8'h5A, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_SACK, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_SACK, 8'hFF, 1'b1, 8'hFF, 1'b1));
      // spare codes between live commands: pin levels must carry over
      send(make_item(ACT_SPARE_LO, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(ACT_SPARE_HI, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(i2cmbs_pkg::CMD_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_START, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_START, 8'h00, 1'b0, 8'h00, 1'b0));
      send(make_item(ACT_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_SACK, 8'h55, 1'b0, 8'hAA, 1'b1));
      send(make_item(i2cmbs_pkg::CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
      drain();

      // Random: mostly transactions, some noise
      rand_base = n_sent;
      while (n_sent - rand_base < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            send_transaction();
         end else begin
            n_noise = $urandom_range(1, 3);
            repeat (n_noise) send(rand_item(3'($urandom_range(7))));
         end
         if (n_sent - rand_base >= 100 && n_sent - rand_base < 110)
            drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/i2cmbs_pkg.sv
hdl/i2cmbs_fifo.sv
hdl/i2cmbs_front.sv
hdl/i2cmbs_back.sv
hdl/i2c_master_bit_sequencer_core.sv
hdl/i2cmbs_checker.sv
verif/i2cmbs_phase_checker.sv
verif/testbench.sv
